>>> design/sfs_pkg.sv
// Shared types and command codes for the sprite frame sequencer.
`timescale 1ns / 1ps

package sfs_pkg;

    typedef enum logic [2:0] {
        OP_TICK      = 3'd0,
        OP_PLAY      = 3'd1,
        OP_SWITCH    = 3'd2,
        OP_FORCE     = 3'd3,
        OP_RST_FRAME = 3'd4,
        OP_WR_DUR    = 3'd5,
        OP_WR_COUNT  = 3'd6,
        OP_WR_LOOP   = 3'd7
    } opcode_t;

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } state_t;

    typedef struct packed {
        opcode_t     opcode;
        logic [3:0]  anim_index;
        logic [5:0]  frame_index;
        logic [15:0] write_value;
    } item_t;

    typedef struct packed {
        logic [3:0] current_anim;
        logic [5:0] current_frame;
        logic       frame_advanced;
    } result_t;

    // Sequencing strobes from the control FSM to the core.
    typedef struct packed {
        logic start;
        logic commit;
    } ctrl_t;

endpackage

>>> design/sfs_dur_mem.sv
// Frame duration memory: one write port, one registered read port.
`timescale 1ns / 1ps

module sfs_dur_mem #(
    parameter int DEPTH  = 1024,
    parameter int ADDR_W = 10,
    parameter int DATA_W = 16
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> design/sfs_core.sv
// Sequencer state, count and loop tables, and the per-command update.
`timescale 1ns / 1ps

module sfs_core import sfs_pkg::*; #(
    parameter int NUM_ANIMS     = 16,
    parameter int MAX_FRAMES    = 64,
    parameter int DURATION_BITS = 16,
    localparam int ANIM_W  = (NUM_ANIMS > 1) ? $clog2(NUM_ANIMS) : 1,
    localparam int FRAME_W = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1,
    localparam int ADDR_W  = ANIM_W + FRAME_W
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  ctrl_t                    ctrl,
    input  item_t                    item,
    output logic                     mem_we,
    output logic [ADDR_W-1:0]        mem_waddr,
    output logic [DURATION_BITS-1:0] mem_wdata,
    output logic                     mem_re,
    output logic [ADDR_W-1:0]        mem_raddr,
    input  logic [DURATION_BITS-1:0] mem_rdata,
    output result_t                  result
);

    localparam int CNT_W  = $clog2(MAX_FRAMES + 1);
    localparam int TICK_W = DURATION_BITS + 1;

    logic [ANIM_W-1:0]  anim_sel_reg, anim_sel_next;
    logic [FRAME_W-1:0] frame_sel_reg, frame_sel_next;
    logic [TICK_W-1:0]  tick_count_reg, tick_count_next;
    item_t              item_reg;

    logic [CNT_W-1:0] count_tab [NUM_ANIMS];
    logic [CNT_W-1:0] loop_tab  [NUM_ANIMS];

    logic               in_anim_ok;
    logic               in_frame_ok;
    logic               anim_ok;
    logic [ANIM_W-1:0]  anim_idx;
    logic [CNT_W-1:0]   sat_value;
    logic               expired;
    logic [TICK_W-1:0]  tick_base;
    logic [FRAME_W:0]   frame_inc;
    logic [CNT_W-1:0]   cnt;
    logic [CNT_W-1:0]   lp;
    logic [FRAME_W-1:0] tick_frame;
    logic               moved;

    // The duration write goes straight from the incoming word; the read
    // fetches the current frame's duration for a possible tick.
    assign in_anim_ok  = 32'(item.anim_index) < NUM_ANIMS;
    assign in_frame_ok = 32'(item.frame_index) < MAX_FRAMES;
    assign mem_we      = ctrl.start && (item.opcode == OP_WR_DUR) && in_anim_ok && in_frame_ok;
    assign mem_waddr   = {ANIM_W'(item.anim_index), FRAME_W'(item.frame_index)};
    assign mem_wdata   = DURATION_BITS'(item.write_value);
    assign mem_re      = ctrl.start;
    assign mem_raddr   = {anim_sel_reg, frame_sel_reg};

    assign anim_ok   = 32'(item_reg.anim_index) < NUM_ANIMS;
    assign anim_idx  = ANIM_W'(item_reg.anim_index);
    assign sat_value = (32'(item_reg.write_value) > MAX_FRAMES) ?
                       CNT_W'(MAX_FRAMES) : CNT_W'(item_reg.write_value);

    // Tick path.
    assign expired   = tick_count_reg > TICK_W'(mem_rdata);
    assign tick_base = expired ? '0 : tick_count_reg;
    assign frame_inc = {1'b0, frame_sel_reg} + 1'b1;
    assign cnt       = count_tab[anim_sel_reg];
    assign lp        = loop_tab[anim_sel_reg];

    always_comb
    begin
        tick_frame = frame_sel_reg;
        if (expired)
        begin
            if (32'(frame_inc) >= 32'(cnt))
            begin
                if (32'(lp) < MAX_FRAMES)
                begin
                    tick_frame = FRAME_W'(lp);
                end
            end
            else
            begin
                tick_frame = FRAME_W'(frame_inc);
            end
        end
    end

    always_comb
    begin
        anim_sel_next   = anim_sel_reg;
        frame_sel_next  = frame_sel_reg;
        tick_count_next = tick_count_reg;
        moved           = 1'b0;
        unique case (item_reg.opcode)
            OP_TICK:
            begin
                frame_sel_next  = tick_frame;
                moved           = tick_frame != frame_sel_reg;
                tick_count_next = (tick_base != '1) ? tick_base + 1'b1 : tick_base;
            end
            OP_PLAY:
            begin
                if (anim_ok && anim_sel_reg != anim_idx)
                begin
                    anim_sel_next   = anim_idx;
                    frame_sel_next  = '0;
                    tick_count_next = '0;
                end
            end
            OP_SWITCH:
            begin
                if (anim_ok && anim_sel_reg != anim_idx)
                begin
                    anim_sel_next   = anim_idx;
                    tick_count_next = '0;
                end
            end
            OP_FORCE:
            begin
                if (anim_ok)
                begin
                    anim_sel_next   = anim_idx;
                    frame_sel_next  = '0;
                    tick_count_next = '0;
                end
            end
            OP_RST_FRAME:
            begin
                frame_sel_next  = (32'(item_reg.frame_index) >= MAX_FRAMES) ?
                                  FRAME_W'(MAX_FRAMES - 1) : FRAME_W'(item_reg.frame_index);
                tick_count_next = '0;
            end
            OP_WR_DUR, OP_WR_COUNT, OP_WR_LOOP:
            begin
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            anim_sel_reg   <= '0;
            frame_sel_reg  <= '0;
            tick_count_reg <= '0;
        end
        else if (ctrl.commit)
        begin
            anim_sel_reg   <= anim_sel_next;
            frame_sel_reg  <= frame_sel_next;
            tick_count_reg <= tick_count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.start)
        begin
            item_reg <= item;
        end
        if (ctrl.commit && anim_ok)
        begin
            if (item_reg.opcode == OP_WR_COUNT)
            begin
                count_tab[anim_idx] <= sat_value;
            end
            if (item_reg.opcode == OP_WR_LOOP)
            begin
                loop_tab[anim_idx] <= sat_value;
            end
        end
    end

    assign result.current_anim   = 4'(anim_sel_next);
    assign result.current_frame  = 6'(frame_sel_next);
    assign result.frame_advanced = moved;

endmodule

>>> design/sprite_frame_sequencer.sv
// Top level of the sprite frame sequencer: handshake FSM and output register.
//
//  Channel  Direction  Word contents
//  s_*      in         opcode, anim_index, frame_index, write_value
//  m_*      out        current_anim, current_frame, frame_advanced
//
// Each word passes through ST_IDLE, which accepts it and issues the duration
// memory read (or write), and then ST_EXEC, which updates the state from the
// read data. A new word is accepted only after the previous one is committed.
// If a result still waits in the output register, the update cycle holds
// until it is taken, and no new word is accepted meanwhile.
// Reset clears the selected animation, frame and tick count; the tables
// hold nothing valid until written.
`timescale 1ns / 1ps

module sprite_frame_sequencer import sfs_pkg::*; #(
    parameter int NUM_ANIMS     = 16,
    parameter int MAX_FRAMES    = 64,
    parameter int DURATION_BITS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // opcode[2:0], anim_index[6:3], frame_index[12:7],
                                   // write_value[28:13], zero fill above
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata    // current_anim[3:0], current_frame[9:4],
                                   // frame_advanced[10], zero fill above
);

    localparam int ANIM_W  = (NUM_ANIMS > 1) ? $clog2(NUM_ANIMS) : 1;
    localparam int FRAME_W = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
    localparam int ADDR_W  = ANIM_W + FRAME_W;
    localparam int DEPTH   = NUM_ANIMS << FRAME_W;

    state_t  state_reg, state_next;
    ctrl_t   ctrl;
    item_t   item;
    result_t result;
    result_t out_reg;
    logic    m_valid_reg, m_valid_next;

    logic                     mem_we;
    logic [ADDR_W-1:0]        mem_waddr;
    logic [DURATION_BITS-1:0] mem_wdata;
    logic                     mem_re;
    logic [ADDR_W-1:0]        mem_raddr;
    logic [DURATION_BITS-1:0] mem_rdata;

    assign item.opcode      = opcode_t'(s_tdata[2:0]);
    assign item.anim_index  = s_tdata[6:3];
    assign item.frame_index = s_tdata[12:7];
    assign item.write_value = s_tdata[28:13];

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (!m_valid_reg || m_tready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        s_tready    = 1'b0;
        ctrl.start  = 1'b0;
        ctrl.commit = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready   = 1'b1;
                ctrl.start = s_tvalid;
            end
            ST_EXEC:
            begin
                ctrl.commit = !m_valid_reg || m_tready;
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        m_valid_next = m_valid_reg;
        if (ctrl.commit)
        begin
            m_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.commit)
        begin
            out_reg <= result;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {5'b0, out_reg.frame_advanced, out_reg.current_frame,
                       out_reg.current_anim};

    sfs_dur_mem #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W),
        .DATA_W (DURATION_BITS)
    ) u_dur_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    sfs_core #(
        .NUM_ANIMS     (NUM_ANIMS),
        .MAX_FRAMES    (MAX_FRAMES),
        .DURATION_BITS (DURATION_BITS)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (ctrl),
        .item      (item),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_re    (mem_re),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata),
        .result    (result)
    );

endmodule
